FILE: hw/rtl/mds_pkg.sv
`default_nettype none

package mds_pkg;

  localparam int unsigned LABEL_W     = 32;
  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  // Width register holds up to MAX_WIDTH itself.
  localparam int unsigned CFG_W       = 12;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);

  // Register word index, taken from paddr[2].
  localparam logic REG_IMAGE_WIDTH = 1'b0;

  // Mode of a 2x2 block with upper pair a,b and lower pair c,d.
  function automatic logic [LABEL_W-1:0] block_mode(
    input logic [LABEL_W-1:0] a,
    input logic [LABEL_W-1:0] b,
    input logic [LABEL_W-1:0] c,
    input logic [LABEL_W-1:0] d
  );
    logic [LABEL_W-1:0] res;
    if ((a == b) || (a == c)) begin
      res = a;
    end else if (b == c) begin
      res = b;
    end else begin
      res = d;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mds_ram.sv
`default_nettype none

module mds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mode_downsample_2x2.sv
// 2x2 mode downsampler for segmentation label images.
// Input stream (s_axis_*): one 32-bit label per transfer in raster order.
// Output stream (m_axis_*): one label per 2x2 block, tlast on the last
// block of each output row. Even input rows only fill the line memory;
// odd input rows give one output transfer on each odd column, an odd
// trailing column gives none.
// APB port: register 0 (byte address 0) is image_width, pixels per input
// row, clamped to 2..2048 in use; reset value 1024. Write it only while
// the block is idle.
// Throughput: one input transfer per clock unless the output stalls, set by
// the line memory, which writes one entry per even-row pixel and reads two
// entries per odd-row pixel in the same cycle.
// The input transfer that completes a block goes through the memory read and
// stage 1, then the output register, before its output appears.
// Reset clears the column and row position, the lower-left register and the
// output valid; the line memory is not cleared and is filled by the first row.
// When the receiver stalls, the output register holds; the block keeps taking
// inputs until the next completed block waits in stage 1, then drops
// s_axis_tready until the output drains.
`default_nettype none

module mode_downsample_2x2
  import mds_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [LABEL_W-1:0]    s_axis_tdata,   // [31:0] pixel_label
  // Output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [LABEL_W-1:0]    m_axis_tdata,   // [31:0] mode_label
  output logic                       m_axis_tlast,   // row_last
  // APB configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // Configuration
  logic [CFG_W-1:0] width_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_IMAGE_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_we) begin
      width_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IMAGE_WIDTH) begin
      prdata = APB_DATA_W'(width_q);
    end
  end

  // Input position
  logic [CFG_W-1:0] w_eff;
  logic [COL_W-1:0] col_q, col_d;
  logic             odd_row_q, odd_row_d;
  logic [COL_W-1:0] col;
  logic             col_end;
  logic             row_last;
  logic             in_xfer;

  // Clamp the width into the supported range.
  always_comb begin
    priority if (width_q < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (width_q > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = width_q;
    end
  end

  logic [CFG_W-1:0] w_last;
  assign w_last = w_eff - CFG_W'(1);

  // Pull the column back inside the row after a width change.
  assign col      = ({1'b0, col_q} >= w_eff) ? w_last[COL_W-1:0] : col_q;
  assign col_end  = ({1'b0, col} == w_last);
  assign row_last = ({1'b0, col} + CFG_W'(2)) >= w_eff;
  assign in_xfer  = s_axis_tvalid & s_axis_tready;

  always_comb begin
    col_d     = col_q;
    odd_row_d = odd_row_q;
    if (in_xfer) begin
      if (col_end) begin
        col_d     = '0;
        odd_row_d = ~odd_row_q;
      end else begin
        col_d = col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      odd_row_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      odd_row_q <= odd_row_d;
    end
  end

  // Line memory: even rows write, odd rows read the upper pair.
  logic [LABEL_W-1:0] upper_a, upper_b;
  logic               mem_we, mem_re;

  assign mem_we = in_xfer & ~odd_row_q;
  assign mem_re = in_xfer &  odd_row_q;

  mds_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (col),
    .wdata_i   (s_axis_tdata),
    .re_i      (mem_re),
    .raddr_a_i ({col[COL_W-1:1], 1'b0}),
    .raddr_b_i (col),
    .rdata_a_o (upper_a),
    .rdata_b_o (upper_b)
  );

  // Stage 1: pixel waits for its memory read.
  logic               s1_valid_q;
  logic               s1_odd_row_q;
  logic               s1_odd_col_q;
  logic               s1_last_q;
  logic [LABEL_W-1:0] s1_pixel_q;
  logic [LABEL_W-1:0] left_lower_q;
  logic               s1_emit;
  logic               s1_adv;
  logic               out_free;

  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign s1_emit       = s1_valid_q & s1_odd_row_q & s1_odd_col_q;
  assign s1_adv        = ~s1_emit | out_free;
  assign s_axis_tready = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_odd_row_q <= odd_row_q;
      s1_odd_col_q <= col[0];
      s1_last_q    <= row_last;
      s1_pixel_q   <= s_axis_tdata;
    end
  end

  // Lower-left pixel of the open block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_lower_q <= '0;
    end else if (s1_valid_q & s1_odd_row_q & ~s1_odd_col_q) begin
      left_lower_q <= s1_pixel_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_emit & out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit & out_free) begin
      m_axis_tdata <= block_mode(upper_a, upper_b, left_lower_q, s1_pixel_q);
      m_axis_tlast <= s1_last_q;
    end
  end

endmodule

`default_nettype wire
